### src/assert_macros.svh
// Assertion helpers for this block. They expect a clock named clk and an
// active-low reset named rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/stm2_pkg.sv
package stm2_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int VALUE_WIDTH = 32;

  // Register and coordinate fields are six bits wide.
  localparam int DIM_W  = 6;
  localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Number of power-of-two levels per dimension: floor(log2(max)) + 1.
  localparam int LVL_R = $clog2(MAX_ROWS + 1);
  localparam int LVL_C = $clog2(MAX_COLS + 1);
  localparam int LVL_W = $clog2(((LVL_R > LVL_C) ? LVL_R : LVL_C) + 1);

  localparam int TABLE_DEPTH = MAX_ROWS * LVL_R * MAX_COLS * LVL_C;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam int IN_DATA_W  = ((4 * DIM_W + VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int CFG_AW     = 3;

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register indexes.
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // Memory control driven by the build sequencer.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              capture;
    logic              done;
  } bld_ctl_t;

  function automatic logic [LVL_W-1:0] floor_log2(input logic [DIM_W-1:0] v);
    logic [LVL_W-1:0] k;
    k = '0;
    for (int i = 1; i < DIM_W; i++) begin
      if (v[i]) begin
        k = LVL_W'(i);
      end
    end
    return k;
  endfunction

  // Zero counts as one, values above the limit count as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] e;
    if (v == '0) begin
      e = DIM_W'(1);
    end else if (v > lim) begin
      e = lim;
    end else begin
      e = v;
    end
    return e;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [ROW_IW-1:0] r,
                                                  input logic [LVL_W-1:0]  kr,
                                                  input logic [COL_IW-1:0] c,
                                                  input logic [LVL_W-1:0]  kc);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(r) * ADDR_W'(LVL_R) + ADDR_W'(kr);
    a = a * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    a = a * ADDR_W'(LVL_C) + ADDR_W'(kc);
    return a;
  endfunction

  function automatic value_t smin(input value_t a, input value_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

### src/sparse_table_min_2d_top.sv
// Channel  Direction  Handshake             Carries
// in_      slave      in_tvalid/in_tready   one cell load or one rectangle query
// out_     master     out_tvalid/out_tready one query result (minimum, error)
// cfg_     APB slave  psel/penable/pready   num_rows at 0x0, num_cols at 0x4
//
// A load is written into the table as it is accepted. A load marked last then
// builds the table, each entry by a check, two reads and a write. A query is
// accepted, makes four reads and a fold; an invalid query skips the reads.
// Reset is synchronous and active low and does not clear the table. A result
// waits in the output register while the next item is taken; a query that ends
// behind a stalled result holds off the input until that result is taken.
`include "assert_macros.svh"

module sparse_table_min_2d_top import stm2_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: row_a[5:0], col_a[11:6], row_b[17:12], col_b[23:18],
  // cell_value[55:24]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]            in_tuser,   // req_type[0]
  input  logic                  in_tlast,   // last_load
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // minimum[31:0]
  output logic [0:0]            out_tuser,  // error[0]
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BUILD = 4'b0010,
    ST_QRD   = 4'b0100,
    ST_QDONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] num_rows_r, num_cols_r, nr, nc;
  logic             built_r;
  logic             cfg_wr, in_acc, is_load, is_query;

  logic [DIM_W-1:0] f_ra, f_ca, f_rb, f_cb;
  value_t           f_val;

  logic             ld_ok, q_err;
  logic [DIM_W-1:0] row_span, col_span, row_pow, col_pow;
  logic [LVL_W-1:0] q_kr, q_kc;

  logic             q_err_r;
  logic [ROW_IW-1:0] q_r0_r, q_r1_r;
  logic [COL_IW-1:0] q_c0_r, q_c1_r;
  logic [LVL_W-1:0] q_kr_r, q_kc_r;
  logic [1:0]       qidx_r;
  value_t           acc_r, min_out;

  logic              mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr, q_addr;
  value_t            mem_wr_data, mem_rd_data;

  bld_ctl_t bld_ctl;
  logic     bld_start;

  logic             out_valid_r, out_err_r, out_load;
  value_t           out_min_r;

  // Field extraction.
  assign f_ra  = in_tdata[DIM_W-1:0];
  assign f_ca  = in_tdata[2*DIM_W-1:DIM_W];
  assign f_rb  = in_tdata[3*DIM_W-1:2*DIM_W];
  assign f_cb  = in_tdata[4*DIM_W-1:3*DIM_W];
  assign f_val = in_tdata[4*DIM_W+VALUE_WIDTH-1:4*DIM_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_load   = in_acc && (in_tuser[0] == REQ_LOAD);
  assign is_query  = in_acc && (in_tuser[0] == REQ_QUERY);

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_NUM_ROWS: cfg_prdata = 32'(num_rows_r);
      REG_NUM_COLS: cfg_prdata = 32'(num_cols_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign nr = eff_dim(num_rows_r, DIM_W'(MAX_ROWS));
  assign nc = eff_dim(num_cols_r, DIM_W'(MAX_COLS));

  // A load outside the matrix in use writes nothing.
  assign ld_ok = (f_ra != '0) && (f_ra <= nr) && (f_ca != '0) && (f_ca <= nc);

  // Corners are checked as given; they are never swapped.
  assign q_err = !built_r || (f_ra == '0) || (f_ca == '0) || (f_ra > f_rb) ||
                 (f_ca > f_cb) || (f_rb > nr) || (f_cb > nc);

  assign row_span = f_rb - f_ra + DIM_W'(1);
  assign col_span = f_cb - f_ca + DIM_W'(1);
  assign q_kr     = floor_log2(row_span);
  assign q_kc     = floor_log2(col_span);
  assign row_pow  = DIM_W'(1) << q_kr;
  assign col_pow  = DIM_W'(1) << q_kc;

  assign bld_start = is_load && in_tlast;

  stm2_build u_build (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bld_start),
    .nr    (nr),
    .nc    (nc),
    .ctl   (bld_ctl)
  );

  // The single compare unit serves both the build and the queries.
  assign min_out = smin(acc_r, mem_rd_data);

  // Query reads in order: top-left, top-right, bottom-left, bottom-right.
  assign q_addr = slot_addr(qidx_r[1] ? q_r1_r : q_r0_r, q_kr_r,
                            qidx_r[0] ? q_c1_r : q_c0_r, q_kc_r);

  always_comb begin
    if (state_r == ST_BUILD) begin
      mem_rd_en   = bld_ctl.rd_en;
      mem_rd_addr = bld_ctl.rd_addr;
      mem_wr_en   = bld_ctl.wr_en;
      mem_wr_addr = bld_ctl.wr_addr;
      mem_wr_data = min_out;
    end else begin
      mem_rd_en   = (state_r == ST_QRD);
      mem_rd_addr = q_addr;
      mem_wr_en   = is_load && ld_ok;
      mem_wr_addr = slot_addr(ROW_IW'(f_ra - DIM_W'(1)), {LVL_W{1'b0}},
                              COL_IW'(f_ca - DIM_W'(1)), {LVL_W{1'b0}});
      mem_wr_data = f_val;
    end
  end

  stm2_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // The result register loads once the previous result has been taken.
  assign out_load = (state_r == ST_QDONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (bld_start) begin
          state_nxt = ST_BUILD;
        end else if (is_query) begin
          state_nxt = q_err ? ST_QDONE : ST_QRD;
        end
      end
      ST_BUILD: begin
        if (bld_ctl.done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRD: begin
        if (qidx_r == 2'd3) begin
          state_nxt = ST_QDONE;
        end
      end
      ST_QDONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_rows_r  <= DIM_W'(MAX_ROWS);
      num_cols_r  <= DIM_W'(MAX_COLS);
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      qidx_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_NUM_ROWS: num_rows_r <= cfg_pwdata[DIM_W-1:0];
          REG_NUM_COLS: num_cols_r <= cfg_pwdata[DIM_W-1:0];
          default:      num_rows_r <= num_rows_r;
        endcase
      end
      priority if (cfg_wr || is_load) begin
        built_r <= 1'b0;
      end else if ((state_r == ST_BUILD) && bld_ctl.done) begin
        built_r <= 1'b1;
      end else begin
        built_r <= built_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_QRD) begin
        qidx_r <= qidx_r + 2'd1;
      end else begin
        qidx_r <= '0;
      end
    end
  end

  // Query operands, the running minimum and the result payload.
  always_ff @(posedge clk) begin
    if (is_query) begin
      q_err_r <= q_err;
      q_kr_r  <= q_kr;
      q_kc_r  <= q_kc;
      q_r0_r  <= ROW_IW'(f_ra - DIM_W'(1));
      q_r1_r  <= ROW_IW'(f_rb - row_pow);
      q_c0_r  <= COL_IW'(f_ca - DIM_W'(1));
      q_c1_r  <= COL_IW'(f_cb - col_pow);
    end
    if ((state_r == ST_BUILD) && bld_ctl.capture) begin
      acc_r <= mem_rd_data;
    end else if ((state_r == ST_QRD) && (qidx_r != 2'd0)) begin
      acc_r <= (qidx_r == 2'd1) ? mem_rd_data : min_out;
    end
    if (out_load) begin
      out_err_r <= q_err_r;
      out_min_r <= q_err_r ? '0 : min_out;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_min_r);
  assign out_tuser  = out_err_r;

  `STM_ASSERT_NOW(a_err_min_zero, out_tvalid && out_tuser[0], out_tdata == '0, "error result with nonzero minimum")
  `STM_ASSERT_NOW(a_qrd_no_err, state_r == ST_QRD, !q_err_r, "table reads for a rejected query")
  `STM_ASSERT_NOW(a_wr_when, mem_wr_en, (state_r == ST_IDLE) || (state_r == ST_BUILD), "table write outside load or build")
  `STM_ASSERT_NEXT(a_build_ends_idle, (state_r == ST_BUILD) && bld_ctl.done, in_tready && !mem_rd_en, "build did not return to idle")

endmodule

### src/stm2_ram.sv
module stm2_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/stm2_build.sv
module stm2_build import stm2_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIM_W-1:0] nr,
  input  logic [DIM_W-1:0] nc,
  output bld_ctl_t         ctl
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_CHK  = 5'b00010,
    B_RA   = 5'b00100,
    B_RB   = 5'b01000,
    B_WR   = 5'b10000
  } bst_t;

  bst_t             st_r, st_nxt;
  logic             ph_r, ph_nxt;
  logic [DIM_W-1:0] r_r, r_nxt, c_r, c_nxt;
  logic [LVL_W-1:0] kr_r, kr_nxt, kc_r, kc_nxt;
  logic [LVL_W-1:0] lr, lc, kr_m1, kc_m1;
  logic [DIM_W:0]   pow_kr, pow_kc, r_end, c_end;
  logic [DIM_W-1:0] half_kr, half_kc;
  logic [ADDR_W-1:0] dst_addr, src_a, src_b;

  assign lr = floor_log2(nr);
  assign lc = floor_log2(nc);

  assign pow_kr  = (DIM_W + 1)'(1) << kr_r;
  assign pow_kc  = (DIM_W + 1)'(1) << kc_r;
  assign half_kr = DIM_W'(pow_kr >> 1);
  assign half_kc = DIM_W'(pow_kc >> 1);
  assign r_end   = {1'b0, r_r} + pow_kr;
  assign c_end   = {1'b0, c_r} + pow_kc;
  assign kr_m1   = kr_r - LVL_W'(1);
  assign kc_m1   = kc_r - LVL_W'(1);

  // Phase 0 widens column spans on single rows, phase 1 widens row spans.
  always_comb begin
    if (ph_r) begin
      dst_addr = slot_addr(ROW_IW'(r_r), kr_r, COL_IW'(c_r), kc_r);
      src_a    = slot_addr(ROW_IW'(r_r), kr_m1, COL_IW'(c_r), kc_r);
      src_b    = slot_addr(ROW_IW'(r_r + half_kr), kr_m1, COL_IW'(c_r), kc_r);
    end else begin
      dst_addr = slot_addr(ROW_IW'(r_r), {LVL_W{1'b0}}, COL_IW'(c_r), kc_r);
      src_a    = slot_addr(ROW_IW'(r_r), {LVL_W{1'b0}}, COL_IW'(c_r), kc_m1);
      src_b    = slot_addr(ROW_IW'(r_r), {LVL_W{1'b0}}, COL_IW'(c_r + half_kc), kc_m1);
    end
  end

  always_comb begin
    ctl.rd_en   = (st_r == B_RA) || (st_r == B_RB);
    ctl.rd_addr = (st_r == B_RB) ? src_b : src_a;
    ctl.wr_en   = (st_r == B_WR);
    ctl.wr_addr = dst_addr;
    ctl.capture = (st_r == B_RB);
    ctl.done    = (st_r == B_CHK) && ph_r && (kr_r > lr);
  end

  always_comb begin
    st_nxt = st_r;
    ph_nxt = ph_r;
    r_nxt  = r_r;
    c_nxt  = c_r;
    kr_nxt = kr_r;
    kc_nxt = kc_r;
    unique case (st_r)
      B_IDLE: begin
        if (start) begin
          st_nxt = B_CHK;
          ph_nxt = 1'b0;
          r_nxt  = '0;
          c_nxt  = '0;
          kr_nxt = '0;
          kc_nxt = LVL_W'(1);
        end
      end
      B_CHK: begin
        if (!ph_r) begin
          priority if (r_r >= nr) begin
            ph_nxt = 1'b1;
            kr_nxt = LVL_W'(1);
            r_nxt  = '0;
            kc_nxt = '0;
            c_nxt  = '0;
          end else if (kc_r > lc) begin
            kc_nxt = LVL_W'(1);
            c_nxt  = '0;
            r_nxt  = r_r + DIM_W'(1);
          end else if (c_end > {1'b0, nc}) begin
            c_nxt  = '0;
            kc_nxt = kc_r + LVL_W'(1);
          end else begin
            st_nxt = B_RA;
          end
        end else begin
          priority if (kr_r > lr) begin
            st_nxt = B_IDLE;
          end else if (r_end > {1'b0, nr}) begin
            r_nxt  = '0;
            kc_nxt = '0;
            c_nxt  = '0;
            kr_nxt = kr_r + LVL_W'(1);
          end else if (kc_r > lc) begin
            kc_nxt = '0;
            c_nxt  = '0;
            r_nxt  = r_r + DIM_W'(1);
          end else if (c_end > {1'b0, nc}) begin
            c_nxt  = '0;
            kc_nxt = kc_r + LVL_W'(1);
          end else begin
            st_nxt = B_RA;
          end
        end
      end
      B_RA: begin
        st_nxt = B_RB;
      end
      B_RB: begin
        st_nxt = B_WR;
      end
      B_WR: begin
        st_nxt = B_CHK;
        c_nxt  = c_r + DIM_W'(1);
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r <= ph_nxt;
    r_r  <= r_nxt;
    c_r  <= c_nxt;
    kr_r <= kr_nxt;
    kc_r <= kc_nxt;
  end

endmodule

### tb/stm2_tb_pkg.sv
package stm2_tb_pkg;
  import stm2_pkg::*;

  // One input item as the sender sees it.
  typedef struct {
    logic             kind;
    logic [DIM_W-1:0] row_a;
    logic [DIM_W-1:0] col_a;
    logic [DIM_W-1:0] row_b;
    logic [DIM_W-1:0] col_b;
    value_t           value;
    logic             last;
  } rect_req_t;

  typedef struct {
    value_t minimum;
    logic   error;
  } rect_answer_t;

  // Keeps its own copy of the matrix and the registers. Once a table is built
  // every aligned sparse-table entry equals the true minimum of its span, so a
  // query answer is the plain minimum over the rectangle.
  class rect_min_scoreboard;
    value_t           grid [MAX_ROWS][MAX_COLS];
    bit               loaded [MAX_ROWS][MAX_COLS];
    bit               built;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    rect_answer_t     answers_due[$];
    int               errors;

    function new();
      built    = 1'b0;
      rows_reg = DIM_W'(MAX_ROWS);
      cols_reg = DIM_W'(MAX_COLS);
      errors   = 0;
    endfunction

    function int clamp_dim(logic [DIM_W-1:0] v, int lim);
      if (v == 0) begin
        return 1;
      end
      return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function int rows_in_use();
      return clamp_dim(rows_reg, MAX_ROWS);
    endfunction

    function int cols_in_use();
      return clamp_dim(cols_reg, MAX_COLS);
    endfunction

    function void note_register(logic idx, logic [DIM_W-1:0] v);
      if (idx == REG_NUM_ROWS) begin
        rows_reg = v;
      end else begin
        cols_reg = v;
      end
      built = 1'b0;
    endfunction

    function void note_request(rect_req_t it);
      int           nr;
      int           nc;
      int           ra;
      int           ca;
      int           rb;
      int           cb;
      value_t       m;
      rect_answer_t ans;
      nr = rows_in_use();
      nc = cols_in_use();
      ra = int'(it.row_a);
      ca = int'(it.col_a);
      rb = int'(it.row_b);
      cb = int'(it.col_b);
      if (it.kind == REQ_LOAD) begin
        if (ra >= 1 && ra <= nr && ca >= 1 && ca <= nc) begin
          grid[ra-1][ca-1]   = it.value;
          loaded[ra-1][ca-1] = 1'b1;
        end
        // Any load drops the table; the marked last one rebuilds it at once.
        built = it.last;
      end else begin
        ans.minimum = '0;
        ans.error   = 1'b1;
        if (built && ra >= 1 && ca >= 1 && ra <= rb && ca <= cb && rb <= nr && cb <= nc) begin
          m = grid[ra-1][ca-1];
          for (int r = ra - 1; r < rb; r++) begin
            for (int c = ca - 1; c < cb; c++) begin
              if (grid[r][c] < m) begin
                m = grid[r][c];
              end
            end
          end
          ans.minimum = m;
          ans.error   = 1'b0;
        end
        answers_due.push_back(ans);
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void check_answer(logic [OUT_DATA_W-1:0] data, logic err);
      rect_answer_t want;
      value_t       got;
      got = value_t'(data[VALUE_WIDTH-1:0]);
      if (answers_due.size() == 0) begin
        flag($sformatf("unexpected result: minimum %0d error %0b", got, err));
        return;
      end
      want = answers_due.pop_front();
      if (got !== want.minimum || err !== want.error) begin
        flag($sformatf("result mismatch: expected minimum %0d error %0b, got minimum %0d error %0b",
                       want.minimum, want.error, got, err));
      end
    endfunction

    function int outstanding();
      return answers_due.size();
    endfunction

    function void close();
      if (answers_due.size() != 0) begin
        flag($sformatf("%0d query results never arrived", answers_due.size()));
      end
    endfunction
  endclass

endpackage

### tb/tb_top.sv
// Testbench for the two-dimensional range-minimum engine.
//
// The main process drives load and query items into the input stream and
// writes the row and column count registers over the APB port whenever the
// engine is idle. Every accepted item is handed to the scoreboard, which
// mirrors the matrix and answers each query by a plain rectangle scan. A
// separate process takes results off the output stream and checks them in
// order against the answers the scoreboard has queued.
module tb_top;
  import stm2_pkg::*;
  import stm2_tb_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_STALL     = 400;
  localparam int RANDOM_ITEMS   = 700;
  localparam int TIMEOUT_CYCLES = 4_000_000;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [0:0]            in_tuser    = '0;
  logic                  in_tlast    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  rect_min_scoreboard sb = new();

  int send_idle_pct = 31;
  int recv_idle_pct = 64;
  int items_sent    = 0;
  bit hold_off      = 1'b0;
  event long_stall_ev;

  sparse_table_min_2d_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // The receiver changes its ready at the falling edge. During a long stall it
  // stays low no matter what the current idle rate says.
  always @(negedge clk) begin
    if (hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Results are taken at the rising edge where valid and ready meet.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_answer(out_tdata, out_tuser[0]);
    end
  end

  // A long receiver stall, counted here in cycles, so the engine backs up and
  // has to drop in_tready while the sender keeps offering items.
  initial begin
    forever begin
      @(long_stall_ev);
      @(posedge clk);
      hold_off = 1'b1;
      repeat (LONG_STALL) @(posedge clk);
      hold_off = 1'b0;
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one item, with random idle cycles in front of it, and returns at
  // the rising edge where it was accepted. The item stays on the bus until
  // the next falling edge, so callers that do not send again must lower valid.
  task automatic push_item(input rect_req_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tlast  <= it.last;
    in_tdata  <= {it.value, it.col_b, it.row_b, it.col_a, it.row_a};
    do @(posedge clk); while (!in_tready);
    sb.note_request(it);
    items_sent++;
  endtask

  // Lowers valid and waits until every queued answer has come back. Each
  // sequence ends with a query, so an empty queue also means no build is
  // still running; the extra cycles cover the output register draining.
  task automatic settle_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [DIM_W-1:0] v);
    logic [31:0] word;
    word       = $urandom;
    word[DIM_W-1:0] = v;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.note_register(idx, v);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic idx, input logic [DIM_W-1:0] v);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[DIM_W-1:0] !== v) begin
      sb.flag($sformatf("register %0d read back %0d, expected %0d",
                        idx, cfg_prdata[DIM_W-1:0], v));
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic rect_req_t mk_item(input logic kind, input int ra, input int ca,
                                        input int rb, input int cb, input value_t v,
                                        input logic last);
    rect_req_t it;
    it.kind  = kind;
    it.row_a = DIM_W'(ra);
    it.col_a = DIM_W'(ca);
    it.row_b = DIM_W'(rb);
    it.col_b = DIM_W'(cb);
    it.value = v;
    it.last  = last;
    return it;
  endfunction

  function automatic value_t rand_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Register values: mostly small sizes, with zero, the maximum and values
  // past the maximum (which clamp) mixed in.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return DIM_W'($urandom_range(MAX_ROWS + 1, 62));
      3:       return DIM_W'(MAX_ROWS);
      4:       return DIM_W'($urandom_range(9, MAX_ROWS - 1));
      default: return DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  // A load, now and then aimed outside the matrix in use so it writes nothing.
  function automatic rect_req_t random_load(input int nr, input int nc, input logic last);
    rect_req_t it;
    it = mk_item(REQ_LOAD, $urandom_range(1, nr), $urandom_range(1, nc),
                 $urandom_range(0, 63), $urandom_range(0, 63), rand_value(), last);
    case ($urandom_range(19))
      0: it.row_a = '0;
      1: it.col_a = '0;
      2: it.row_a = DIM_W'($urandom_range(nr + 1, 63));
      3: it.col_a = DIM_W'($urandom_range(nc + 1, 63));
      default: ;
    endcase
    return it;
  endfunction

  // Mostly well-formed rectangles; the rest have a zero corner, reversed
  // corners or a corner past the rows or columns in use.
  function automatic rect_req_t random_query(input int nr, input int nc);
    rect_req_t it;
    int        ra;
    int        ca;
    ra = $urandom_range(1, nr);
    ca = $urandom_range(1, nc);
    it = mk_item(REQ_QUERY, ra, ca, $urandom_range(ra, nr), $urandom_range(ca, nc),
                 value_t'($urandom), $urandom_range(1));
    case ($urandom_range(39))
      0: it.row_a = '0;
      1: it.col_a = '0;
      2: begin
        if (nr > 1) begin
          it.row_a = DIM_W'($urandom_range(2, nr));
          it.row_b = DIM_W'($urandom_range(1, int'(it.row_a) - 1));
        end else begin
          it.row_b = '0;
        end
      end
      3: begin
        if (nc > 1) begin
          it.col_a = DIM_W'($urandom_range(2, nc));
          it.col_b = DIM_W'($urandom_range(1, int'(it.col_a) - 1));
        end else begin
          it.col_b = '0;
        end
      end
      4: it.row_b = DIM_W'($urandom_range(nr + 1, 63));
      5: it.col_b = DIM_W'($urandom_range(nc + 1, 63));
      6, 7: begin
        it.row_a = DIM_W'(1);
        it.col_a = DIM_W'(1);
        it.row_b = DIM_W'(nr);
        it.col_b = DIM_W'(nc);
      end
      default: ;
    endcase
    return it;
  endfunction

  // One configuration and its traffic: set both registers, load a few cells,
  // make sure every cell in use holds a value, build with a marked last load,
  // then query. The build never reads a cell that was not loaded.
  task automatic run_session(input bit full_size, input bit with_stall);
    logic [DIM_W-1:0] rows_raw;
    logic [DIM_W-1:0] cols_raw;
    int               nr;
    int               nc;
    int               n_queries;
    if (full_size) begin
      rows_raw  = DIM_W'(MAX_ROWS / 2);
      cols_raw  = DIM_W'(MAX_COLS / 2);
      n_queries = 40;
    end else begin
      rows_raw  = pick_dim();
      cols_raw  = pick_dim();
      // Keep builds short; a matrix of more than 256 cells gets one to eight columns.
      if (sb.clamp_dim(rows_raw, MAX_ROWS) * sb.clamp_dim(cols_raw, MAX_COLS) > 256) begin
        cols_raw = DIM_W'($urandom_range(1, 8));
      end
      n_queries = $urandom_range(5, 30);
    end
    settle_idle();
    apb_write(REG_NUM_ROWS, rows_raw);
    apb_write(REG_NUM_COLS, cols_raw);
    apb_read_check(REG_NUM_ROWS, rows_raw);
    apb_read_check(REG_NUM_COLS, cols_raw);
    nr = sb.rows_in_use();
    nc = sb.cols_in_use();
    // The register write dropped the table, so this query must report an error.
    if ($urandom_range(3) == 0) begin
      push_item(random_query(nr, nc));
    end
    repeat ($urandom_range(0, 8)) push_item(random_load(nr, nc, 1'b0));
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (!sb.loaded[r][c]) begin
          push_item(mk_item(REQ_LOAD, r + 1, c + 1, $urandom_range(0, 63),
                            $urandom_range(0, 63), rand_value(), 1'b0));
        end
      end
    end
    push_item(random_load(nr, nc, 1'b1));
    // Now and then a load slips in between queries. Without the last mark it
    // leaves the table unbuilt and the following queries report errors.
    // The long stall starts once the first query is in, after the build, so
    // results pile up behind it while the sender keeps going.
    repeat (n_queries) begin
      if ($urandom_range(19) == 0) begin
        push_item(random_load(nr, nc, $urandom_range(1)));
      end
      push_item(random_query(nr, nc));
      if (with_stall) begin
        -> long_stall_ev;
        with_stall = 1'b0;
      end
    end
  endtask

  initial begin
    value_t dvals [9];
    int     base;
    int     phase;
    int     last_phase;

    dvals = '{32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1, 32'sh8000_0000,
              32'sd5, -32'sd7, 32'sd100, 32'sh8000_0001};

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Right after reset nothing is built, so even a
    // well-formed query over the whole matrix reports an error.
    push_item(mk_item(REQ_QUERY, 1, 1, MAX_ROWS, MAX_COLS, '0, 1'b0));

    // A one by one matrix holding the most negative value.
    settle_idle();
    apb_write(REG_NUM_ROWS, DIM_W'(1));
    apb_write(REG_NUM_COLS, DIM_W'(1));
    push_item(mk_item(REQ_LOAD, 1, 1, 0, 0, 32'sh8000_0000, 1'b1));
    push_item(mk_item(REQ_QUERY, 1, 1, 1, 1, '0, 1'b0));
    push_item(mk_item(REQ_QUERY, 0, 1, 1, 1, '0, 1'b0));
    push_item(mk_item(REQ_QUERY, 1, 1, 2, 1, '0, 1'b1));
    // A load outside the matrix writes nothing but still drops the table;
    // one marked last rebuilds it.
    push_item(mk_item(REQ_LOAD, 0, 63, 63, 63, 32'sh7FFF_FFFF, 1'b0));
    push_item(mk_item(REQ_QUERY, 1, 1, 1, 1, '0, 1'b0));
    push_item(mk_item(REQ_LOAD, 5, 5, 0, 0, -32'sd1, 1'b1));
    push_item(mk_item(REQ_QUERY, 1, 1, 1, 1, '0, 1'b0));

    // A three by three matrix with the value extremes, then reversed and
    // out-of-range corners.
    settle_idle();
    apb_write(REG_NUM_ROWS, DIM_W'(3));
    apb_write(REG_NUM_COLS, DIM_W'(3));
    for (int i = 0; i < 9; i++) begin
      push_item(mk_item(REQ_LOAD, i / 3 + 1, i % 3 + 1, 0, 0, dvals[i], i == 8));
    end
    push_item(mk_item(REQ_QUERY, 1, 1, 3, 3, '0, 1'b0));
    push_item(mk_item(REQ_QUERY, 2, 2, 3, 3, '0, 1'b0));
    push_item(mk_item(REQ_QUERY, 3, 1, 1, 3, '0, 1'b0));
    push_item(mk_item(REQ_QUERY, 1, 3, 3, 1, '0, 1'b0));
    push_item(mk_item(REQ_QUERY, 1, 1, 3, 4, '0, 1'b0));

    // One large square matrix, so deep levels in both directions get built
    // together.
    run_session(1'b1, 1'b0);

    // Random sessions over three idle profiles. A long receiver stall opens
    // each profile.
    base       = items_sent;
    last_phase = -1;
    while (items_sent - base < RANDOM_ITEMS) begin
      phase = (items_sent - base) * 3 / RANDOM_ITEMS;
      if (phase != last_phase) begin
        case (phase)
          0: begin
            send_idle_pct = 31;
            recv_idle_pct = 64;
          end
          1: begin
            send_idle_pct = 64;
            recv_idle_pct = 31;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
      end
      run_session(1'b0, phase != last_phase);
      last_phase = phase;
    end

    settle_idle();
    sb.close();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
